// ----- sv/dsfl_pkg.sv -----
// Package for the descending sorted free list.
// Holds the capacity, widths, status and opcode codes, and the slot and RAM port types.
// No dependencies.
package dsfl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SIZE_W   = 16;
  localparam int OFF_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] rec_size;
    logic [OFF_W-1:0]  rec_offset;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- sv/dsfl_ram.sv -----
// Slot storage for the free list: one write port, one registered read port.
// Depends on dsfl_pkg.
module dsfl_ram (
  input  logic              clk,
  input  dsfl_pkg::ram_req_t req,
  output dsfl_pkg::entry_t  rdata
);

  dsfl_pkg::entry_t mem [dsfl_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- sv/descending_sorted_free_list_core.sv -----
// Top level of the descending sorted free list: sequencer and result register.
// Depends on dsfl_pkg and dsfl_ram.
//
// Keeps up to 64 freed records (offset, size) ordered largest size first, in a
// single-port-write slot RAM with a registered read. One transaction at a time is
// in work; in_stall is high from acceptance until the result is handed to the
// output register. An insert walks from the tail, moving one entry per cycle
// while each entry is strictly smaller than the new size. A find walks from
// slot 0, one slot per cycle, up to the first slot whose size is no larger
// than the requested size. An insert into an empty or a full list, or a find
// on an empty one, skips the walk. A finished result waits while out_stall
// holds the output register, and the output register holds a result while
// out_stall is high.
module descending_sorted_free_list_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [dsfl_pkg::OFF_W-1:0]    in_record_offset,
  input  logic [dsfl_pkg::SIZE_W-1:0]   in_record_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsfl_pkg::STAT_W-1:0]   out_status,
  output logic [dsfl_pkg::IDX_W-1:0]    out_slot_index,
  output logic [dsfl_pkg::CNT_W-1:0]    out_entry_count
);

  typedef enum logic [2:0] {S_IDLE, S_INS, S_HEAD, S_FND, S_DONE} state_t;

  state_t                        state_r, state_nxt;
  logic [dsfl_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [dsfl_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  dsfl_pkg::entry_t              key_r, key_nxt;
  logic [dsfl_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [dsfl_pkg::IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [dsfl_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [dsfl_pkg::IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic [dsfl_pkg::CNT_W-1:0]    out_count_r, out_count_nxt;

  dsfl_pkg::ram_req_t            ram_req;
  dsfl_pkg::entry_t              ram_rdata;
  logic                          out_free;

  dsfl_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_entry_count = out_count_r;
  assign out_free        = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    ram_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt.rec_size   = in_record_size;
          key_nxt.rec_offset = in_record_offset;
          res_slot_nxt       = '0;
          res_status_nxt     = dsfl_pkg::ST_OK;
          if (in_op == dsfl_pkg::OP_INSERT) begin
            if (count_r == dsfl_pkg::CNT_W'(dsfl_pkg::CAPACITY)) begin
              res_status_nxt = dsfl_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else if (count_r == '0) begin
              ram_req.we               = 1'b1;
              ram_req.waddr            = '0;
              ram_req.wdata.rec_size   = in_record_size;
              ram_req.wdata.rec_offset = in_record_offset;
              count_nxt                = count_r + dsfl_pkg::CNT_W'(1);
              state_nxt                = S_DONE;
            end else begin
              ram_req.raddr = dsfl_pkg::IDX_W'(count_r - dsfl_pkg::CNT_W'(1));
              idx_nxt       = count_r;
              state_nxt     = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = dsfl_pkg::ST_NONE;
              state_nxt      = S_DONE;
            end else begin
              ram_req.raddr = '0;
              idx_nxt       = '0;
              state_nxt     = S_FND;
            end
          end
        end
      end

      // ram_rdata holds slot idx_r-1; shift it up while strictly smaller
      S_INS: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[dsfl_pkg::IDX_W-1:0];
        if (ram_rdata.rec_size < key_r.rec_size) begin
          ram_req.wdata = ram_rdata;
          if (idx_r == dsfl_pkg::CNT_W'(1)) begin
            state_nxt = S_HEAD;
          end else begin
            ram_req.raddr = dsfl_pkg::IDX_W'(idx_r - dsfl_pkg::CNT_W'(2));
            idx_nxt       = idx_r - dsfl_pkg::CNT_W'(1);
          end
        end else begin
          ram_req.wdata = key_r;
          count_nxt     = count_r + dsfl_pkg::CNT_W'(1);
          state_nxt     = S_DONE;
        end
      end

      S_HEAD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = key_r;
        count_nxt     = count_r + dsfl_pkg::CNT_W'(1);
        state_nxt     = S_DONE;
      end

      // ram_rdata holds slot idx_r
      S_FND: begin
        if (ram_rdata.rec_size <= key_r.rec_size) begin
          res_status_nxt = dsfl_pkg::ST_OK;
          res_slot_nxt   = idx_r[dsfl_pkg::IDX_W-1:0];
          state_nxt      = S_DONE;
        end else if (idx_r == count_r - dsfl_pkg::CNT_W'(1)) begin
          res_status_nxt = dsfl_pkg::ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          ram_req.raddr = dsfl_pkg::IDX_W'(idx_r + dsfl_pkg::CNT_W'(1));
          idx_nxt       = idx_r + dsfl_pkg::CNT_W'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dsfl_pkg::CNT_W'(dsfl_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == dsfl_pkg::ST_FULL)
      |-> out_count_r == dsfl_pkg::CNT_W'(dsfl_pkg::CAPACITY))
    else $error("full status with room left");

  a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != dsfl_pkg::ST_OK) |-> out_slot_r == '0)
    else $error("nonzero slot on failed transaction");

  a_find_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FND) |-> idx_r < count_r)
    else $error("find walk past last entry");

endmodule

// ----- verif/tb_descending_sorted_free_list_core.sv -----
`timescale 1ns / 100ps
// Testbench for descending_sorted_free_list_core: directed and random insert/find traffic.
// A local free-list predictor scores each result; random idle on both sides. Needs dsfl_pkg.
module tb_descending_sorted_free_list_core;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * dsfl_pkg::CAPACITY + 16;

  typedef struct packed {
    logic [dsfl_pkg::STAT_W-1:0] status;
    logic [dsfl_pkg::IDX_W-1:0]  slot_index;
    logic [dsfl_pkg::CNT_W-1:0]  entry_count;
  } fl_result_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_op            = dsfl_pkg::OP_INSERT;
  logic [dsfl_pkg::OFF_W-1:0]  in_record_offset = '0;
  logic [dsfl_pkg::SIZE_W-1:0] in_record_size   = '0;
  logic                        out_stall        = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic [dsfl_pkg::STAT_W-1:0] out_status;
  logic [dsfl_pkg::IDX_W-1:0]  out_slot_index;
  logic [dsfl_pkg::CNT_W-1:0]  out_entry_count;

  // predictor copy of the list
  logic [dsfl_pkg::SIZE_W-1:0] list_size [dsfl_pkg::CAPACITY];
  logic [dsfl_pkg::OFF_W-1:0]  list_offset [dsfl_pkg::CAPACITY];
  int                          list_count = 0;

  fl_result_t pending_results[$];
  int         fail_count  = 0;
  int         in_gap_pct  = 30;
  int         stall_pct   = 30;
  bit         hold_req    = 1'b0;

  descending_sorted_free_list_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_record_offset (in_record_offset),
    .in_record_size   (in_record_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic fl_result_t free_list_predict(
      input logic op,
      input logic [dsfl_pkg::OFF_W-1:0] off,
      input logic [dsfl_pkg::SIZE_W-1:0] size);
    fl_result_t r;
    int         pos;
    r.status     = dsfl_pkg::ST_OK;
    r.slot_index = '0;
    if (op == dsfl_pkg::OP_INSERT) begin
      if (list_count >= dsfl_pkg::CAPACITY) begin
        r.status = dsfl_pkg::ST_FULL;
      end else begin
        pos = list_count;
        for (int i = 0; i < list_count; i++) begin
          if (pos == list_count && list_size[i] < size) pos = i;
        end
        for (int i = list_count; i > pos; i--) begin
          list_size[i]   = list_size[i-1];
          list_offset[i] = list_offset[i-1];
        end
        list_size[pos]   = size;
        list_offset[pos] = off;
        list_count++;
      end
    end else begin
      r.status = dsfl_pkg::ST_NONE;
      for (int i = 0; i < list_count; i++) begin
        if (r.status == dsfl_pkg::ST_NONE && list_size[i] <= size) begin
          r.status     = dsfl_pkg::ST_OK;
          r.slot_index = i[dsfl_pkg::IDX_W-1:0];
        end
      end
    end
    r.entry_count = list_count[dsfl_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(15) == 0) return $urandom_range(30, 5);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [dsfl_pkg::SIZE_W-1:0] pick_insert_size();
    case ($urandom_range(9))
      0, 1, 2, 3: return dsfl_pkg::SIZE_W'($urandom_range(8, 1) * 256);
      4:          return '0;
      5:          return '1;
      default:    return dsfl_pkg::SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [dsfl_pkg::SIZE_W-1:0] pick_find_size();
    if (list_count > 0 && $urandom_range(1) == 0)
      return list_size[$urandom_range(list_count - 1)]
             + dsfl_pkg::SIZE_W'($urandom_range(2)) - 1'b1;
    return pick_insert_size();
  endfunction

  // receiver side: random stalls plus an on-demand long hold
  initial begin
    int n;
    logic v;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        v = 1'b1;
        n = HOLD_CYCLES;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        v = 1'b1;
        n = gap_len();
      end else begin
        v = 1'b0;
        n = 1;
      end
      out_stall <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    fl_result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot_index %0d entry_count %0d",
               out_status, out_slot_index, out_entry_count);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_slot_index !== exp_r.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_r.slot_index, out_slot_index);
          fail_count++;
        end
        if (out_entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [dsfl_pkg::OFF_W-1:0] off,
                           input logic [dsfl_pkg::SIZE_W-1:0] size);
    int n;
    in_valid         <= 1'b1;
    in_op            <= op;
    in_record_offset <= off;
    in_record_size   <= size;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(free_list_predict(op, off, size));
    n = ($urandom_range(99) < in_gap_pct) ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(input int insert_pct);
    if ($urandom_range(99) < insert_pct)
      send_item(dsfl_pkg::OP_INSERT, $urandom, pick_insert_size());
    else
      send_item(dsfl_pkg::OP_FIND, $urandom, pick_find_size());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic test_empty_find();
    send_item(dsfl_pkg::OP_FIND, '0, '0);
    send_item(dsfl_pkg::OP_FIND, '1, '1);
  endtask

  task automatic test_ordering();
    send_item(dsfl_pkg::OP_INSERT, '0, 16'h8000);
    send_item(dsfl_pkg::OP_INSERT, '1, 16'hFFFF);
    send_item(dsfl_pkg::OP_INSERT, 32'h5A5A_5A5A, 16'h0000);
    send_item(dsfl_pkg::OP_INSERT, 32'h0000_1234, 16'h8000);   // ties stay in arrival order
    send_item(dsfl_pkg::OP_FIND, '0, 16'h8000);
    send_item(dsfl_pkg::OP_FIND, '0, 16'hFFFF);
    send_item(dsfl_pkg::OP_FIND, '0, 16'h0000);
    send_item(dsfl_pkg::OP_FIND, '0, 16'h7FFF);
    send_item(dsfl_pkg::OP_FIND, '0, 16'h8001);
    send_item(dsfl_pkg::OP_FIND, '0, 16'hFFFE);
    send_item(dsfl_pkg::OP_INSERT, 32'hA5A5_A5A5, 16'h0001);
    send_item(dsfl_pkg::OP_INSERT, 32'h8000_0001, 16'hFFFF);
    send_item(dsfl_pkg::OP_FIND, '1, 16'h0000);
    send_item(dsfl_pkg::OP_FIND, '1, 16'h0001);
  endtask

  task automatic test_fill_random();
    while (list_count < dsfl_pkg::CAPACITY) send_random(70);
  endtask

  task automatic test_hold_off();
    hold_req = 1'b1;
    repeat (12) send_random(50);
    drain_results();
  endtask

  task automatic test_full_list();
    send_item(dsfl_pkg::OP_INSERT, '1, 16'hFFFF);
    send_item(dsfl_pkg::OP_INSERT, '0, 16'h0000);
    send_item(dsfl_pkg::OP_FIND, '0, 16'hFFFF);
    send_item(dsfl_pkg::OP_FIND, '0, 16'h0000);
    send_item(dsfl_pkg::OP_FIND, '0, list_size[dsfl_pkg::CAPACITY-1]);
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 0) begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end else begin
        in_gap_pct = $urandom_range(60);
        stall_pct  = $urandom_range(60);
      end
      repeat (100) send_random(30);
      if (seg % 2 == 1) drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_find();
    test_ordering();
    test_fill_random();
    test_hold_off();
    test_full_list();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
